// ===== rtl/etf_pkg.sv =====
// ----------------------------------------------------------------------------
// etf_pkg: shared types and constants for the escape-time fractal block
// Fixed port widths, config register indexes, sequencer states and the
// control word that drives the shared multiplier.
// ----------------------------------------------------------------------------
package etf_pkg;

    localparam int PT_W       = 32;
    localparam int CNT_W      = 16;
    localparam int MOD_W      = 41;
    localparam int RAD_W      = 35;
    localparam int MAXIT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 35;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JRE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JIM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAXIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd4;

    localparam logic MODE_MANDEL = 1'b0;

    localparam logic [MAXIT_W-1:0] MAXIT_RESET = 16'd1000;

    typedef struct packed {
        logic start;
        logic dbl;
    } mul_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BULB_SQA,
        ST_BULB_SQY,
        ST_BULB_CARD,
        ST_BULB_SQB,
        ST_SQ_X,
        ST_SQ_Y,
        ST_CHECK,
        ST_MUL_XY,
        ST_OUT
    } etf_state_t;

endpackage

// ===== rtl/etf_mul.sv =====
// ----------------------------------------------------------------------------
// etf_mul: shared signed fixed-point multiplier
// Four half-width partial products accumulated over cycles, then a right
// shift by FRAC_BITS (or FRAC_BITS-1 for a doubled product), magnitude clamp
// and sign.
// ----------------------------------------------------------------------------
module etf_mul #(
    parameter int FRAC_BITS = 28
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  etf_pkg::mul_ctl_t            ctl,
    input  logic signed [FRAC_BITS+22:0] a,
    input  logic signed [FRAC_BITS+22:0] b,
    output logic                         done,
    output logic signed [FRAC_BITS+20:0] res
);
    import etf_pkg::*;

    localparam int SW = FRAC_BITS + 23;
    localparam int MW = SW - 1;
    localparam int HW = (MW + 1) / 2;
    localparam int DW = 2 * HW;
    localparam int PW = 4 * HW;
    localparam int RW = FRAC_BITS + 20;

    localparam logic [2:0] NUM_PP     = 3'd4;
    localparam logic [2:0] STEP_CLAMP = 3'd5;
    localparam logic [2:0] STEP_SIGN  = 3'd6;

    logic          busy_reg;
    logic [2:0]    cnt_reg;
    logic          done_reg;
    logic          pp_vld_reg;
    logic [DW-1:0] a_mag_reg;
    logic [DW-1:0] b_mag_reg;
    logic          neg_reg;
    logic          dbl_reg;
    logic [DW-1:0] pp_reg;
    logic [1:0]    pp_k_reg;
    logic [PW-1:0] acc_reg;
    logic [RW-1:0] mag_reg;
    logic signed [RW:0] res_reg;

    logic [SW-1:0] a_abs;
    logic [SW-1:0] b_abs;
    logic [HW-1:0] a_half;
    logic [HW-1:0] b_half;
    logic [DW-1:0] pp_next;
    logic [PW-1:0] term;
    logic [PW-1:0] shifted;
    logic [RW-1:0] mag_next;
    logic signed [RW:0] res_next;

    always_comb
    begin
        a_abs  = a[SW-1] ? ($unsigned(~a) + SW'(1)) : $unsigned(a);
        b_abs  = b[SW-1] ? ($unsigned(~b) + SW'(1)) : $unsigned(b);
        a_half = cnt_reg[1] ? a_mag_reg[DW-1:HW] : a_mag_reg[HW-1:0];
        b_half = cnt_reg[0] ? b_mag_reg[DW-1:HW] : b_mag_reg[HW-1:0];
        pp_next = a_half * b_half;
        unique case (pp_k_reg)
            2'b00:   term = PW'(pp_reg);
            2'b01:   term = PW'(pp_reg) << HW;
            2'b10:   term = PW'(pp_reg) << HW;
            default: term = PW'(pp_reg) << (2 * HW);
        endcase
        shifted  = dbl_reg ? (acc_reg >> (FRAC_BITS - 1)) : (acc_reg >> FRAC_BITS);
        mag_next = (|shifted[PW-1:RW]) ? '1 : shifted[RW-1:0];
        res_next = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            pp_vld_reg <= 1'b0;
        end
        else
        begin
            done_reg   <= busy_reg && (cnt_reg == STEP_SIGN);
            pp_vld_reg <= busy_reg && (cnt_reg < NUM_PP);
            if (ctl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == STEP_SIGN)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg)
        begin
            a_mag_reg <= DW'(a_abs[MW-1:0]);
            b_mag_reg <= DW'(b_abs[MW-1:0]);
            neg_reg   <= a[SW-1] ^ b[SW-1];
            dbl_reg   <= ctl.dbl;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg   <= pp_next;
            pp_k_reg <= cnt_reg[1:0];
            if (pp_vld_reg)
            begin
                acc_reg <= acc_reg + term;
            end
            if (cnt_reg == STEP_CLAMP)
            begin
                mag_reg <= mag_next;
            end
            if (cnt_reg == STEP_SIGN)
            begin
                res_reg <= res_next;
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/escape_time_fractal_iteration.sv =====
// ----------------------------------------------------------------------------
// escape_time_fractal_iteration: Mandelbrot / Julia escape-time iterator
// One point in, one result word out: iteration count, final |z|^2 and a
// limit flag. All multiplications run through one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one point word; in_stall stays
//   high while a point is being worked on. Output channel (out_valid/
//   out_stall) presents one result word held in an output register, so a
//   new point is taken while an earlier result still waits on out_stall.
//   Config channel (cfg_valid/cfg_ready) writes registers by index; write
//   only while the block is idle. cfg_ready is always high.
//   Every product goes through the shared multiplier, and one iteration
//   needs three products plus an escape check.
//   Mandelbrot: a bulb test of four products, then the iterations.
//   Julia: the starting squares, then the iterations.
//   Reset clears the sequencer, the output valid and loads the config
//   defaults (Mandelbrot, limit 1000, radius^2 4.0).
//   A stalled result holds the block in its output state until taken.
// ----------------------------------------------------------------------------
module escape_time_fractal_iteration #(
    parameter int FRAC_BITS  = 28,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [etf_pkg::PT_W-1:0]     point_re,
    input  logic signed [etf_pkg::PT_W-1:0]     point_im,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [etf_pkg::CNT_W-1:0]           iteration_count,
    output logic [etf_pkg::MOD_W-1:0]           final_modulus_sq,
    output logic                                reached_limit,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [etf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [etf_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import etf_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int CB  = COUNT_BITS;
    localparam int SW  = F + 23;
    localparam int RW  = F + 20;
    localparam int ZW  = F + 8;
    localparam int XW  = (ZW > PT_W) ? ZW : PT_W;
    localparam int MDW = F + 13;
    localparam int RDW = (RAD_W > F + 3) ? RAD_W : F + 3;
    localparam int CMW = (RW + 1 > RDW) ? RW + 1 : RDW;
    localparam int LW  = MAXIT_W + CB;

    localparam logic signed [SW-1:0] ONE_S       = {{(SW-1){1'b0}}, 1'b1} << F;
    localparam logic signed [SW-1:0] QUARTER_S   = {{(SW-1){1'b0}}, 1'b1} << (F - 2);
    localparam logic signed [SW-1:0] SIXTEENTH_S = {{(SW-1){1'b0}}, 1'b1} << (F - 4);
    localparam logic signed [SW-1:0] Z_MAX_S = {{(SW-ZW+1){1'b0}}, {(ZW-1){1'b1}}};
    localparam logic signed [SW-1:0] Z_MIN_S = {{(SW-ZW+1){1'b1}}, {(ZW-1){1'b0}}};
    localparam logic [RDW-1:0] RAD_RESET = {{(RDW-1){1'b0}}, 1'b1} << (F + 2);
    localparam logic [LW-1:0]  COUNT_MAX = {{MAXIT_W{1'b0}}, {CB{1'b1}}};

    // config registers
    logic                    mode_reg;
    logic signed [PT_W-1:0]  jre_reg;
    logic signed [PT_W-1:0]  jim_reg;
    logic [MAXIT_W-1:0]      maxit_reg;
    logic [RDW-1:0]          radius_reg;

    // control
    etf_state_t state_reg, state_next;
    logic       start_reg, start_next;
    logic       out_valid_reg, out_valid_next;

    // datapath
    logic signed [XW-1:0]   x_reg, x_next;
    logic signed [XW-1:0]   y_reg, y_next;
    logic signed [PT_W-1:0] cre_reg, cre_next;
    logic signed [PT_W-1:0] cim_reg, cim_next;
    logic signed [SW-1:0]   t_reg, t_next;
    logic signed [SW-1:0]   u_reg, u_next;
    logic [RW-1:0]          xs_reg, xs_next;
    logic [RW-1:0]          ys_reg, ys_next;
    logic                   hit_reg, hit_next;
    logic [CB-1:0]          n_reg, n_next;
    logic [CB-1:0]          limit_reg, limit_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [MOD_W-1:0]       mod_reg, mod_next;
    logic                   reach_reg, reach_next;

    // shared multiplier
    mul_ctl_t               mul_ctl;
    logic signed [SW-1:0]   op_a;
    logic signed [SW-1:0]   op_b;
    logic                   mul_done;
    logic signed [RW:0]     mul_res;

    logic                   in_take;
    logic [CB-1:0]          limit_sat;
    logic signed [SW-1:0]   res_s;
    logic signed [SW-1:0]   xs_s;
    logic signed [SW-1:0]   ys_s;
    logic signed [SW-1:0]   ysq_s;
    logic signed [SW-1:0]   q_s;
    logic [RW:0]            sum_m;
    logic [MDW-1:0]         mod_clamp;

    function automatic logic signed [SW-1:0] sat_z(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = v;
        if (v > Z_MAX_S)
        begin
            r = Z_MAX_S;
        end
        else if (v < Z_MIN_S)
        begin
            r = Z_MIN_S;
        end
        return r;
    endfunction

    etf_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mul_ctl),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;

    assign mul_ctl.start = start_reg;
    assign mul_ctl.dbl   = (state_reg == ST_MUL_XY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MANDEL;
            jre_reg    <= '0;
            jim_reg    <= '0;
            maxit_reg  <= MAXIT_RESET;
            radius_reg <= RAD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_JRE:    jre_reg    <= cfg_data[PT_W-1:0];
                REG_JIM:    jim_reg    <= cfg_data[PT_W-1:0];
                REG_MAXIT:  maxit_reg  <= cfg_data[MAXIT_W-1:0];
                REG_RADIUS: radius_reg <= RDW'(cfg_data[RAD_W-1:0]);
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        limit_sat = (LW'(maxit_reg) > COUNT_MAX) ? '1 : CB'(maxit_reg);
        res_s     = SW'(mul_res);
        xs_s      = SW'({1'b0, xs_reg});
        ys_s      = SW'({1'b0, ys_reg});
        ysq_s     = SW'({1'b0, ys_reg[RW-1:2]});
        q_s       = u_reg + res_s;
        sum_m     = (RW+1)'(xs_reg) + (RW+1)'(ys_reg);
        mod_clamp = (|sum_m[RW:MDW]) ? '1 : sum_m[MDW-1:0];
    end

    always_comb
    begin
        unique case (state_reg)
            ST_BULB_SQA:  begin op_a = t_reg;       op_b = t_reg;       end
            ST_BULB_SQY:  begin op_a = SW'(y_reg);  op_b = SW'(y_reg);  end
            ST_BULB_CARD: begin op_a = u_reg;       op_b = t_reg;       end
            ST_BULB_SQB:  begin op_a = t_reg;       op_b = t_reg;       end
            ST_SQ_X:      begin op_a = SW'(x_reg);  op_b = SW'(x_reg);  end
            ST_SQ_Y:      begin op_a = SW'(y_reg);  op_b = SW'(y_reg);  end
            ST_MUL_XY:    begin op_a = SW'(x_reg);  op_b = SW'(y_reg);  end
            default:      begin op_a = '0;          op_b = '0;          end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        x_next         = x_reg;
        y_next         = y_reg;
        cre_next       = cre_reg;
        cim_next       = cim_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        hit_next       = hit_reg;
        n_next         = n_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        mod_next       = mod_reg;
        reach_next     = reach_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    x_next     = XW'(point_re);
                    y_next     = XW'(point_im);
                    n_next     = '0;
                    limit_next = limit_sat;
                    start_next = 1'b1;
                    if (mode_reg == MODE_MANDEL)
                    begin
                        cre_next   = point_re;
                        cim_next   = point_im;
                        t_next     = SW'(point_re) - QUARTER_S;
                        state_next = ST_BULB_SQA;
                    end
                    else
                    begin
                        cre_next   = jre_reg;
                        cim_next   = jim_reg;
                        state_next = ST_SQ_X;
                    end
                end
            end
            ST_BULB_SQA:
            begin
                if (mul_done)
                begin
                    u_next     = res_s;
                    start_next = 1'b1;
                    state_next = ST_BULB_SQY;
                end
            end
            ST_BULB_SQY:
            begin
                if (mul_done)
                begin
                    ys_next    = mul_res[RW-1:0];
                    u_next     = q_s;
                    t_next     = q_s + t_reg;
                    start_next = 1'b1;
                    state_next = ST_BULB_CARD;
                end
            end
            ST_BULB_CARD:
            begin
                if (mul_done)
                begin
                    hit_next   = (res_s < ysq_s);
                    t_next     = SW'(x_reg) + ONE_S;
                    start_next = 1'b1;
                    state_next = ST_BULB_SQB;
                end
            end
            ST_BULB_SQB:
            begin
                if (mul_done)
                begin
                    xs_next = '0;
                    ys_next = '0;
                    if (hit_reg || ((res_s + ys_s) < SIXTEENTH_S))
                    begin
                        n_next     = limit_reg;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        x_next     = '0;
                        y_next     = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_SQ_X:
            begin
                if (mul_done)
                begin
                    xs_next    = mul_res[RW-1:0];
                    start_next = 1'b1;
                    state_next = ST_SQ_Y;
                end
            end
            ST_SQ_Y:
            begin
                if (mul_done)
                begin
                    ys_next    = mul_res[RW-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if ((CMW'(sum_m) <= CMW'(radius_reg)) && (n_reg < limit_reg))
                begin
                    start_next = 1'b1;
                    state_next = ST_MUL_XY;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL_XY:
            begin
                if (mul_done)
                begin
                    x_next     = XW'(sat_z(xs_s - ys_s + SW'(cre_reg)));
                    y_next     = XW'(sat_z(res_s + SW'(cim_reg)));
                    n_next     = n_reg + CB'(1);
                    start_next = 1'b1;
                    state_next = ST_SQ_X;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    count_next     = CNT_W'(n_reg);
                    mod_next       = MOD_W'(mod_clamp);
                    reach_next     = (n_reg == limit_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        cre_reg   <= cre_next;
        cim_reg   <= cim_next;
        t_reg     <= t_next;
        u_reg     <= u_next;
        xs_reg    <= xs_next;
        ys_reg    <= ys_next;
        hit_reg   <= hit_next;
        n_reg     <= n_next;
        limit_reg <= limit_next;
        count_reg <= count_next;
        mod_reg   <= mod_next;
        reach_reg <= reach_next;
    end

    assign out_valid        = out_valid_reg;
    assign iteration_count  = count_reg;
    assign final_modulus_sq = mod_reg;
    assign reached_limit    = reach_reg;

    // multiplier results only arrive while the sequencer waits on one
    a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_BULB_SQA || state_reg == ST_BULB_SQY ||
                      state_reg == ST_BULB_CARD || state_reg == ST_BULB_SQB ||
                      state_reg == ST_SQ_X || state_reg == ST_SQ_Y ||
                      state_reg == ST_MUL_XY))
        else $error("multiplier done outside a multiply state");

    a_iter_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_XY) |-> (n_reg < limit_reg))
        else $error("iteration started at or past the limit");

    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result word raised outside the output state");

    a_start_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |=> !mul_done)
        else $error("multiplier done right after start");

endmodule

// ===== test/tb_escape_time_fractal_iteration.sv =====
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_iteration: self-checking bench for the escape-time core
// Sends complex points under several register settings (Mandelbrot and Julia,
// zero, small and full iteration limits, zero to oversized radii). Expected
// words come from a bit-true fixed-point model held in a small ledger class.
// Both channels idle in random bursts; one long output hold-off backs up the
// input. A watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_iteration;

    timeunit 1ns;
    timeprecision 1ps;

    import etf_pkg::*;

    localparam int FRAC_BITS       = 28;
    localparam int Q_ONE           = 1 << FRAC_BITS;
    localparam int HOLD_CYCLES     = 3000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int WATCHDOG_CYCLES = 200000;

    localparam logic                 MODE_JULIA = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [PT_W-1:0] P_MIN = 32'sh8000_0000;
    localparam logic signed [PT_W-1:0] P_MAX = 32'sh7FFF_FFFF;

    typedef longint unsigned u64_t;

    localparam longint ONE_Q    = longint'(1) <<< FRAC_BITS;
    localparam u64_t   PROD_CAP = (u64_t'(1) << (20 + FRAC_BITS)) - 1;
    localparam longint Z_MAX    = (longint'(1) <<< (7 + FRAC_BITS)) - 1;
    localparam longint Z_MIN    = -(longint'(1) <<< (7 + FRAC_BITS));
    localparam u64_t   MOD_MAX  = (u64_t'(1) << (13 + FRAC_BITS)) - 1;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [MOD_W-1:0] modsq;
        logic             at_limit;
    } escape_word_t;

    class escape_ledger;
        logic         mode_r;
        longint       jc_re;
        longint       jc_im;
        int unsigned  iter_limit;
        u64_t         radius_sq;
        escape_word_t expected_words[$];
        int unsigned  failures;
        int unsigned  reported;

        function new();
            mode_r     = MODE_MANDEL;
            jc_re      = 0;
            jc_im      = 0;
            iter_limit = MAXIT_RESET;
            radius_sq  = u64_t'(ONE_Q) << 2;
            failures   = 0;
            reported   = 0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:   mode_r = data[0];
                REG_JRE:    jc_re = $signed(data[PT_W-1:0]);
                REG_JIM:    jc_im = $signed(data[PT_W-1:0]);
                REG_MAXIT:  iter_limit = data[MAXIT_W-1:0];
                REG_RADIUS: radius_sq = data[RAD_W-1:0];
                default:    ;
            endcase
        endfunction

        function u64_t mul_trunc(u64_t a, u64_t b, int sh);
            logic [127:0] p;
            p = ({64'd0, a} * {64'd0, b}) >> sh;
            if (p > PROD_CAP)
                return PROD_CAP;
            return p[63:0];
        endfunction

        function u64_t magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint scaled_mul(longint a, longint b, int sh);
            u64_t m;
            m = mul_trunc(magnitude(a), magnitude(b), sh);
            return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        endfunction

        function longint square(longint v);
            return longint'(mul_trunc(magnitude(v), magnitude(v), FRAC_BITS));
        endfunction

        function longint clamp_z(longint v);
            if (v > Z_MAX)
                return Z_MAX;
            if (v < Z_MIN)
                return Z_MIN;
            return v;
        endfunction

        // main cardioid, then period-2 disc
        function bit in_bulbs(longint x, longint y);
            longint a, ys, q, lhs, b;
            a   = x - (ONE_Q >>> 2);
            ys  = square(y);
            q   = square(a) + ys;
            lhs = scaled_mul(q, q + a, FRAC_BITS);
            b   = x + ONE_Q;
            if (lhs < (ys >>> 2))
                return 1'b1;
            return (square(b) + ys) < (ONE_Q >>> 4);
        endfunction

        function escape_word_t iterate(logic signed [PT_W-1:0] pre,
                                       logic signed [PT_W-1:0] pim);
            longint       x, y, cre, cim, xs, ys, nx, ny;
            int unsigned  n;
            u64_t         modsq;
            escape_word_t w;
            n = 0;
            if (mode_r == MODE_MANDEL) begin
                if (in_bulbs(pre, pim)) begin
                    w.count    = iter_limit[CNT_W-1:0];
                    w.modsq    = '0;
                    w.at_limit = 1'b1;
                    return w;
                end
                x   = 0;
                y   = 0;
                cre = pre;
                cim = pim;
            end
            else begin
                x   = pre;
                y   = pim;
                cre = jc_re;
                cim = jc_im;
            end
            xs = square(x);
            ys = square(y);
            while (u64_t'(xs + ys) <= radius_sq && n < iter_limit) begin
                nx = clamp_z(xs - ys + cre);
                ny = clamp_z(scaled_mul(x, y, FRAC_BITS - 1) + cim);
                x  = nx;
                y  = ny;
                xs = square(x);
                ys = square(y);
                n++;
            end
            modsq = u64_t'(xs + ys);
            if (modsq > MOD_MAX)
                modsq = MOD_MAX;
            w.count    = n[CNT_W-1:0];
            w.modsq    = modsq[MOD_W-1:0];
            w.at_limit = (n == iter_limit);
            return w;
        endfunction

        function void note_point(logic signed [PT_W-1:0] re, logic signed [PT_W-1:0] im);
            expected_words.push_back(iterate(re, im));
        endfunction

        function void check_result(logic [CNT_W-1:0] count, logic [MOD_W-1:0] modsq,
                                   logic at_limit);
            escape_word_t w;
            if (expected_words.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected word: count %0d modsq %h limit %b",
                             count, modsq, at_limit);
                end
                return;
            end
            w = expected_words.pop_front();
            if (w.count !== count || w.modsq !== modsq || w.at_limit !== at_limit) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch: count %0d/%0d modsq %h/%h limit %b/%b (exp/act)",
                             w.count, count, w.modsq, modsq, w.at_limit, at_limit);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_words.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic signed [PT_W-1:0] point_re = '0;
    logic signed [PT_W-1:0] point_im = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [CNT_W-1:0]       iteration_count;
    logic [MOD_W-1:0]       final_modulus_sq;
    logic                   reached_limit;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    escape_ledger ledger;
    bit           idling = 1'b0;
    bit           hold_request = 1'b0;
    int unsigned  stall_left = 0;

    escape_time_fractal_iteration i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .point_re         (point_re),
        .point_im         (point_im),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .iteration_count  (iteration_count),
        .final_modulus_sq (final_modulus_sq),
        .reached_limit    (reached_limit),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            ledger.check_result(iteration_count, final_modulus_sq, reached_limit);
    end

    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (hold_request) begin
            hold_request = 1'b0;
            out_stall  <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
        end
        else if (idling && $urandom_range(0, 5) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_escape_time_fractal_iteration: FAIL");
        $finish;
    end

    task automatic send_point(input logic signed [PT_W-1:0] re,
                              input logic signed [PT_W-1:0] im);
        if (idling && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        point_re <= re;
        point_im <= im;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ledger.note_point(re, im);
    endtask

    task automatic finish_points();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ledger.load_reg(idx, data);
    endtask

    // upper data bits beyond each register's width carry junk
    task automatic apply_config(input logic mode, input logic [PT_W-1:0] jre,
                                input logic [PT_W-1:0] jim, input logic [MAXIT_W-1:0] maxit,
                                input logic [RAD_W-1:0] radius);
        put_reg(REG_MODE, {34'($urandom), mode});
        put_reg(REG_JRE, {3'($urandom), jre});
        put_reg(REG_JIM, {3'($urandom), jim});
        put_reg(REG_MAXIT, {19'($urandom), maxit});
        put_reg(REG_RADIUS, radius);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config(output logic mode);
        logic [PT_W-1:0]    jre, jim;
        logic [RAD_W-1:0]   radius;
        logic [MAXIT_W-1:0] maxit;
        mode = $urandom_range(0, 1) ? MODE_JULIA : MODE_MANDEL;
        if ($urandom_range(0, 3) == 0) begin
            jre = $urandom;
            jim = $urandom;
        end
        else begin
            jre = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
            jim = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
        end
        maxit = $urandom_range(1, 32);
        case ($urandom_range(0, 4))
            0:       radius = 35'd4 << FRAC_BITS;
            1:       radius = 35'd64 << FRAC_BITS;
            2:       radius = 35'($urandom_range(1, 64)) << FRAC_BITS;
            3:       radius = 35'({$urandom, $urandom});
            default: radius = '0;
        endcase
        apply_config(mode, jre, jim, maxit, radius);
    endtask

    task automatic pick_plane_point(input logic mode, output logic signed [PT_W-1:0] re,
                                    output logic signed [PT_W-1:0] im);
        if ($urandom_range(0, 99) < 15) begin
            re = $urandom;
            im = $urandom;
        end
        else if (mode == MODE_JULIA) begin
            re = $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
            im = $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
        end
        else begin
            re = $urandom_range(0, Q_ONE / 2 * 7) - Q_ONE / 2 * 5;
            im = $urandom_range(0, 3 * Q_ONE) - Q_ONE / 2 * 3;
        end
    endtask

    // deep in a bulb or far outside: quick even with the full limit
    task automatic pick_quick_point(output logic signed [PT_W-1:0] re,
                                    output logic signed [PT_W-1:0] im);
        case ($urandom_range(0, 3))
            0: begin
                re = $urandom_range(0, Q_ONE / 4) - Q_ONE / 8;
                im = $urandom_range(0, Q_ONE / 4) - Q_ONE / 8;
            end
            1: begin
                re = $urandom_range(0, Q_ONE / 5) - Q_ONE / 10 - Q_ONE;
                im = $urandom_range(0, Q_ONE / 5) - Q_ONE / 10;
            end
            default: begin
                re = $urandom_range(Q_ONE / 2 * 5, 32'h7FFF_FFFF);
                if ($urandom_range(0, 1))
                    re = -re;
                im = $urandom;
            end
        endcase
    endtask

    initial
    begin
        logic signed [PT_W-1:0] re, im;
        logic                   mode;
        ledger = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: Mandelbrot, limit 1000, radius^2 4.0
        idling = 1'b1;
        send_point(0, 0);
        send_point(-Q_ONE, 0);
        send_point(Q_ONE / 4, 0);
        send_point(2 * Q_ONE, 0);
        send_point(P_MIN, P_MIN);
        send_point(P_MAX, P_MAX);
        send_point(P_MIN, P_MAX);
        send_point(P_MAX, P_MIN);
        send_point(-Q_ONE / 4 * 3, Q_ONE / 10);
        send_point(Q_ONE / 10 * 3, Q_ONE / 2);
        finish_points();

        // zero limit
        apply_config(MODE_MANDEL, 0, 0, 0, 35'd4 << FRAC_BITS);
        send_point(0, 0);
        send_point(2 * Q_ONE, 2 * Q_ONE);
        finish_points();

        // single iteration, zero radius
        apply_config(MODE_JULIA, -Q_ONE / 5 * 4, Q_ONE / 1000 * 156, 1, '0);
        send_point(0, 0);
        send_point(Q_ONE / 2, Q_ONE / 2);
        send_point(P_MAX, P_MIN);
        finish_points();

        // extreme constant, radius beyond 64.0, modulus saturation
        apply_config(MODE_JULIA, P_MIN, P_MAX, 3, '1);
        send_point(0, 0);
        send_point(P_MAX, P_MAX);
        send_point(-Q_ONE, Q_ONE / 2);
        finish_points();

        // unknown index, then full limit
        put_reg(REG_UNUSED, 35'({$urandom, $urandom}));
        apply_config(MODE_MANDEL, 0, 0, '1, 35'd64 << FRAC_BITS);
        send_point(0, 0);
        send_point(-Q_ONE, 0);
        send_point(3 * Q_ONE, -2 * Q_ONE);
        send_point(P_MIN, 0);
        finish_points();

        for (int p = 0; p < 7; p++) begin
            random_config(mode);
            idling = (p % 3 != 2);
            if (p == 1)
                hold_request = 1'b1;
            for (int k = 0; k < 70; k++) begin
                pick_plane_point(mode, re, im);
                send_point(re, im);
            end
            finish_points();
        end

        idling = 1'b1;
        apply_config(MODE_MANDEL, $urandom, $urandom, '1, 35'd4 << FRAC_BITS);
        for (int k = 0; k < 40; k++) begin
            pick_quick_point(re, im);
            send_point(re, im);
        end
        finish_points();

        random_config(mode);
        idling = 1'b0;
        for (int k = 0; k < 38; k++) begin
            pick_plane_point(mode, re, im);
            send_point(re, im);
        end
        finish_points();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("tb_escape_time_fractal_iteration: PASS");
        else
            $display("tb_escape_time_fractal_iteration: FAIL");
        $finish;
    end

endmodule
